/* rtl/core/bht_pkg.sv */
// Shared types and constants for the bone hierarchy transform block.
package bht_pkg;

    localparam int ELEM_W        = 32;
    localparam int ROWS          = 4;
    localparam int FRAC_W        = 16;
    localparam int PROD_W        = 2 * ELEM_W;
    localparam int ACC_W         = PROD_W - FRAC_W + 2;
    localparam int ROW_W         = ELEM_W * ROWS;
    localparam int BONE_W        = 6;
    localparam int ROWNUM_W      = 2;
    localparam int ADDR_FULL_W   = 12;
    localparam int BONE_CMP_W    = 11;
    localparam int CNT_W         = 3;
    localparam int MAX_BONES_DEF = 64;

    localparam logic [CNT_W-1:0] CNT_LAST = 3'd5;

    typedef struct packed {
        logic signed [ELEM_W-1:0]   local_elem_0;
        logic signed [ELEM_W-1:0]   local_elem_1;
        logic signed [ELEM_W-1:0]   local_elem_2;
        logic signed [ELEM_W-1:0]   local_elem_3;
        logic        [ROWNUM_W-1:0] row_number;
        logic        [BONE_W-1:0]   bone_index;
        logic                       has_parent;
        logic        [BONE_W-1:0]   parent_index;
    } t_in_beat;

    typedef struct packed {
        logic signed [ELEM_W-1:0]   abs_elem_0;
        logic signed [ELEM_W-1:0]   abs_elem_1;
        logic signed [ELEM_W-1:0]   abs_elem_2;
        logic signed [ELEM_W-1:0]   abs_elem_3;
        logic        [ROWNUM_W-1:0] out_row_number;
        logic        [BONE_W-1:0]   out_bone_index;
    } t_out_beat;

    typedef logic [ROWS-1:0][ELEM_W-1:0] t_row;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic                clear;
        logic                mul_en;
        logic                acc_en;
        logic [ROWNUM_W-1:0] k_sel;
    } t_mac_ctrl;

endpackage

/* rtl/core/bht_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bht_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/bht_mac.sv */
// Four-lane Q16.16 multiply-accumulate for one absolute row, with saturation.
module bht_mac (
    input  logic                       i_clk,
    input  bht_pkg::t_mac_ctrl         i_ctrl,
    input  bht_pkg::t_row              i_local,
    input  logic [bht_pkg::ROW_W-1:0]  i_rd_data,
    output bht_pkg::t_row              o_row
);

    localparam logic [bht_pkg::ELEM_W-1:0] SAT_MAX = {1'b0, {(bht_pkg::ELEM_W-1){1'b1}}};
    localparam logic [bht_pkg::ELEM_W-1:0] SAT_MIN = {1'b1, {(bht_pkg::ELEM_W-1){1'b0}}};
    localparam int HI_W = bht_pkg::ACC_W - bht_pkg::ELEM_W + 1;

    logic signed [bht_pkg::ELEM_W-1:0] w_local_sel;

    assign w_local_sel = i_local[i_ctrl.k_sel];

    for (genvar j = 0; j < bht_pkg::ROWS; j++) begin : g_lane
        logic signed [bht_pkg::ELEM_W-1:0] w_parent;
        logic signed [bht_pkg::PROD_W-1:0] r_prod;
        logic signed [bht_pkg::PROD_W-1:0] n_prod;
        logic signed [bht_pkg::ACC_W-1:0]  r_acc;
        logic signed [bht_pkg::ACC_W-1:0]  n_acc;
        logic        [HI_W-1:0]            w_hi;
        logic        [bht_pkg::ELEM_W-1:0] w_sat;

        assign w_parent = i_rd_data[j*bht_pkg::ELEM_W +: bht_pkg::ELEM_W];
        assign n_prod   = w_local_sel * w_parent;

        always_comb begin
            n_acc = r_acc;
            if (i_ctrl.clear) begin
                n_acc = '0;
            end else if (i_ctrl.acc_en) begin
                n_acc = r_acc + {{2{r_prod[bht_pkg::PROD_W-1]}},
                                 r_prod[bht_pkg::PROD_W-1:bht_pkg::FRAC_W]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctrl.mul_en) begin
                r_prod <= n_prod;
            end
            r_acc <= n_acc;
        end

        assign w_hi = r_acc[bht_pkg::ACC_W-1:bht_pkg::ELEM_W-1];

        always_comb begin
            if ((&w_hi) || !(|w_hi)) begin
                w_sat = r_acc[bht_pkg::ELEM_W-1:0];
            end else if (r_acc[bht_pkg::ACC_W-1]) begin
                w_sat = SAT_MIN;
            end else begin
                w_sat = SAT_MAX;
            end
        end

        assign o_row[j] = w_sat;
    end

endmodule

/* rtl/core/bone_hierarchy_transform_top.sv */
// Top level of the bone hierarchy transform: sequencer, row store and output register.
//
// Each input beat carries one row of a bone's local 4x4 Q16.16 transform; one
// beat of the absolute row comes out for each. A root-bone row goes from the
// input register through the finish state into the output register. For a
// child row the parent's four rows are first read from the row store one per
// cycle over its single read port, each feeding four multipliers and
// accumulators, then the saturated row is written back and registered for
// output. Each row is taken in the idle state; a finished row waits in the
// finish state while the output stall holds the output register. The block
// holds one row at a time; o_in_stall is high from acceptance until the result
// has been loaded into the output register. Parents must be sent before their
// children. The store needs no clearing pass after reset.
module bone_hierarchy_transform_top #(
    parameter int MAX_BONES = bht_pkg::MAX_BONES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bht_pkg::t_in_beat i_in_beat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bht_pkg::t_out_beat o_out_beat
);

    localparam int DEPTH  = MAX_BONES * bht_pkg::ROWS;
    localparam int ADDR_W = $clog2(DEPTH);

    bht_pkg::t_state    r_state;
    bht_pkg::t_state    n_state;
    bht_pkg::t_in_beat  r_in;
    bht_pkg::t_out_beat r_out;
    bht_pkg::t_out_beat n_out;
    logic               r_out_vld;
    logic [bht_pkg::CNT_W-1:0] r_cnt;

    logic               w_accept;
    logic               w_out_free;
    logic               w_parent_ok;
    logic               w_bone_ok;
    logic               w_rd_en;
    logic               w_wr_en;
    logic               w_out_load;
    bht_pkg::t_mac_ctrl w_mac_ctrl;
    bht_pkg::t_row      w_local;
    bht_pkg::t_row      w_acc_row;
    bht_pkg::t_row      w_res_row;
    logic [bht_pkg::ROW_W-1:0] w_rd_data;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [ADDR_W-1:0]  w_wr_addr;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_vld || !i_out_stall;
    assign w_parent_ok = {5'b0, i_in_beat.parent_index}
                         < bht_pkg::BONE_CMP_W'(MAX_BONES);
    assign w_bone_ok   = {5'b0, r_in.bone_index} < bht_pkg::BONE_CMP_W'(MAX_BONES);

    assign w_rd_addr = ADDR_W'({{(bht_pkg::ADDR_FULL_W - bht_pkg::BONE_W
                                  - bht_pkg::ROWNUM_W){1'b0}},
                                r_in.parent_index, r_cnt[bht_pkg::ROWNUM_W-1:0]});
    assign w_wr_addr = ADDR_W'({{(bht_pkg::ADDR_FULL_W - bht_pkg::BONE_W
                                  - bht_pkg::ROWNUM_W){1'b0}},
                                r_in.bone_index, r_in.row_number});

    assign w_local = {r_in.local_elem_3, r_in.local_elem_2,
                      r_in.local_elem_1, r_in.local_elem_0};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bht_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_beat.has_parent && w_parent_ok) begin
                        n_state = bht_pkg::ST_MUL;
                    end else begin
                        n_state = bht_pkg::ST_FIN;
                    end
                end
            end
            bht_pkg::ST_MUL: begin
                if (r_cnt == bht_pkg::CNT_LAST) begin
                    n_state = bht_pkg::ST_FIN;
                end
            end
            bht_pkg::ST_FIN: begin
                if (w_out_free) begin
                    n_state = bht_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bht_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        w_rd_en           = 1'b0;
        w_wr_en           = 1'b0;
        w_out_load        = 1'b0;
        o_in_stall        = 1'b1;
        w_mac_ctrl.clear  = 1'b0;
        w_mac_ctrl.mul_en = 1'b0;
        w_mac_ctrl.acc_en = 1'b0;
        w_mac_ctrl.k_sel  = bht_pkg::ROWNUM_W'(r_cnt - 3'd1);
        case (r_state)
            bht_pkg::ST_IDLE: begin
                o_in_stall       = 1'b0;
                w_mac_ctrl.clear = w_accept;
            end
            bht_pkg::ST_MUL: begin
                w_rd_en           = !r_cnt[bht_pkg::CNT_W-1];
                w_mac_ctrl.mul_en = r_cnt inside {[3'd1:3'd4]};
                w_mac_ctrl.acc_en = r_cnt inside {[3'd2:3'd5]};
            end
            bht_pkg::ST_FIN: begin
                w_out_load = w_out_free;
                w_wr_en    = w_out_free && w_bone_ok;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign w_res_row = r_in.has_parent ? w_acc_row : w_local;

    always_comb begin
        n_out.abs_elem_0     = w_res_row[0];
        n_out.abs_elem_1     = w_res_row[1];
        n_out.abs_elem_2     = w_res_row[2];
        n_out.abs_elem_3     = w_res_row[3];
        n_out.out_row_number = r_in.row_number;
        n_out.out_bone_index = r_in.bone_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bht_pkg::ST_IDLE;
            r_out_vld <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (w_accept) begin
                r_cnt <= '0;
            end else if (r_state == bht_pkg::ST_MUL) begin
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_beat;
        end
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    bht_ram #(
        .WIDTH (bht_pkg::ROW_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_res_row),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    bht_mac u_mac (
        .i_clk     (i_clk),
        .i_ctrl    (w_mac_ctrl),
        .i_local   (w_local),
        .i_rd_data (w_rd_data),
        .o_row     (w_acc_row)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

endmodule

/* rtl/core/bht_chk.sv */
// Port-level checker for the bone hierarchy transform, bound to the top level.
module bht_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input bht_pkg::t_in_beat  i_in_beat,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input bht_pkg::t_out_beat o_out_beat
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && !o_in_stall;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("stalled output beat changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input taken while a row is in work");

    a_root_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !o_out_valid && !i_in_beat.has_parent |=> ##1
            o_out_valid
            && o_out_beat.abs_elem_0 == $past(i_in_beat.local_elem_0, 2)
            && o_out_beat.abs_elem_3 == $past(i_in_beat.local_elem_3, 2)
            && o_out_beat.out_bone_index == $past(i_in_beat.bone_index, 2))
        else $error("root row not passed through");

endmodule

bind bone_hierarchy_transform_top bht_chk u_bht_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_beat   (i_in_beat),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

/* bench/bht_checker.sv */
// Checker for the bone hierarchy transform: predicts each absolute row and compares output beats.
module bht_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  bht_pkg::t_in_beat  i_in_beat,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  bht_pkg::t_out_beat i_out_beat,
    output int                 o_err_count,
    output int                 o_pending
);

    localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SAT_LO = 64'shFFFF_FFFF_8000_0000;

    logic signed [bht_pkg::ELEM_W-1:0]
        abs_store [bht_pkg::MAX_BONES_DEF][bht_pkg::ROWS][bht_pkg::ROWS];
    bht_pkg::t_out_beat abs_row_q [$];

    initial begin
        o_err_count = 0;
        o_pending   = 0;
    end

    task automatic report_mismatch(input string what,
                                   input logic [bht_pkg::ELEM_W-1:0] got,
                                   input logic [bht_pkg::ELEM_W-1:0] want);
        $display("mismatch %s: got %h, want %h", what, got, want);
        o_err_count++;
    endtask

    function automatic bht_pkg::t_out_beat predict_abs_row(input bht_pkg::t_in_beat b);
        logic signed [bht_pkg::ELEM_W-1:0] lrow [bht_pkg::ROWS];
        logic signed [bht_pkg::ELEM_W-1:0] arow [bht_pkg::ROWS];
        longint                            acc;
        bht_pkg::t_out_beat                r;
        lrow[0] = b.local_elem_0;
        lrow[1] = b.local_elem_1;
        lrow[2] = b.local_elem_2;
        lrow[3] = b.local_elem_3;
        for (int j = 0; j < bht_pkg::ROWS; j++) begin
            if (!b.has_parent) begin
                arow[j] = lrow[j];
            end else begin
                acc = 0;
                for (int k = 0; k < bht_pkg::ROWS; k++) begin
                    acc += (longint'(lrow[k]) * longint'(abs_store[b.parent_index][k][j]))
                           >>> bht_pkg::FRAC_W;
                end
                if (acc > SAT_HI) begin
                    acc = SAT_HI;
                end else if (acc < SAT_LO) begin
                    acc = SAT_LO;
                end
                arow[j] = acc[bht_pkg::ELEM_W-1:0];
            end
        end
        r.abs_elem_0     = arow[0];
        r.abs_elem_1     = arow[1];
        r.abs_elem_2     = arow[2];
        r.abs_elem_3     = arow[3];
        r.out_row_number = b.row_number;
        r.out_bone_index = b.bone_index;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        bht_pkg::t_out_beat want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                want = predict_abs_row(i_in_beat);
                abs_store[i_in_beat.bone_index][i_in_beat.row_number][0] = want.abs_elem_0;
                abs_store[i_in_beat.bone_index][i_in_beat.row_number][1] = want.abs_elem_1;
                abs_store[i_in_beat.bone_index][i_in_beat.row_number][2] = want.abs_elem_2;
                abs_store[i_in_beat.bone_index][i_in_beat.row_number][3] = want.abs_elem_3;
                abs_row_q.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                if (abs_row_q.size() == 0) begin
                    report_mismatch("beat with no row expected", i_out_beat.abs_elem_0, '0);
                end else begin
                    want = abs_row_q.pop_front();
                    if (i_out_beat.abs_elem_0 !== want.abs_elem_0)
                        report_mismatch("abs_elem_0", i_out_beat.abs_elem_0, want.abs_elem_0);
                    if (i_out_beat.abs_elem_1 !== want.abs_elem_1)
                        report_mismatch("abs_elem_1", i_out_beat.abs_elem_1, want.abs_elem_1);
                    if (i_out_beat.abs_elem_2 !== want.abs_elem_2)
                        report_mismatch("abs_elem_2", i_out_beat.abs_elem_2, want.abs_elem_2);
                    if (i_out_beat.abs_elem_3 !== want.abs_elem_3)
                        report_mismatch("abs_elem_3", i_out_beat.abs_elem_3, want.abs_elem_3);
                    if (i_out_beat.out_row_number !== want.out_row_number)
                        report_mismatch("out_row_number", 32'(i_out_beat.out_row_number),
                                        32'(want.out_row_number));
                    if (i_out_beat.out_bone_index !== want.out_bone_index)
                        report_mismatch("out_bone_index", 32'(i_out_beat.out_bone_index),
                                        32'(want.out_bone_index));
                end
            end
            o_pending = abs_row_q.size();
        end
    end

endmodule

/* bench/tb_top.sv */
// Testbench top: feeds bone rows to the transform block with random gaps and stalls.
module tb_top;

    localparam int RANDOM_ROWS = 1380;
    localparam int CYCLE_LIMIT = 1_000_000;

    localparam logic signed [bht_pkg::ELEM_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [bht_pkg::ELEM_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [bht_pkg::ELEM_W-1:0] Q_ONE = 32'sh0001_0000;

    logic               clk       = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    bht_pkg::t_in_beat  in_beat;
    logic               out_valid;
    logic               out_stall = 1'b0;
    bht_pkg::t_out_beat out_beat;

    int err_count;
    int pending;
    int cycles     = 0;
    int stall_left = 0;
    int rows_sent  = 0;
    int mood_until = 0;
    bit calm       = 1'b0;

    logic [bht_pkg::ROWS-1:0] rows_done [bht_pkg::MAX_BONES_DEF];

    bone_hierarchy_transform_top #(
        .MAX_BONES(bht_pkg::MAX_BONES_DEF)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_beat  (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_beat (out_beat)
    );

    bht_checker chk (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_stall (in_stall),
        .i_in_beat  (in_beat),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_out_beat (out_beat),
        .o_err_count(err_count),
        .o_pending  (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk) begin : stall_gen
        int r;
        if (!rst_n || calm) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                out_stall  <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end else if (r < 90) begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end else begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(10, 40);
            end
        end
    end

    function automatic bht_pkg::t_in_beat make_row(
        input logic signed [bht_pkg::ELEM_W-1:0] e0, e1, e2, e3,
        input int row, input int bone,
        input bit hp, input int par);
        bht_pkg::t_in_beat b;
        b.local_elem_0 = e0;
        b.local_elem_1 = e1;
        b.local_elem_2 = e2;
        b.local_elem_3 = e3;
        b.row_number   = row[bht_pkg::ROWNUM_W-1:0];
        b.bone_index   = bone[bht_pkg::BONE_W-1:0];
        b.has_parent   = hp;
        b.parent_index = par[bht_pkg::BONE_W-1:0];
        return b;
    endfunction

    function automatic logic signed [bht_pkg::ELEM_W-1:0] pick_elem();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return int'($urandom_range(0, 524288)) - 262144;
        if (r < 55) return ($urandom_range(0, 1) ? Q_ONE : -Q_ONE)
                           + int'($urandom_range(0, 4096)) - 2048;
        if (r < 85) return $urandom();
        case ($urandom_range(0, 5))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return -1;
            4:       return 1;
            default: return -Q_ONE;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // any bone whose four rows have all been written, or -1
    function automatic int pick_full_bone();
        int full_q [$];
        for (int i = 0; i < bht_pkg::MAX_BONES_DEF; i++) begin
            if (rows_done[i] == '1) full_q.push_back(i);
        end
        if (full_q.size() == 0) return -1;
        return full_q[$urandom_range(0, full_q.size() - 1)];
    endfunction

    task automatic push_row(input bht_pkg::t_in_beat b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        rows_done[b.bone_index][b.row_number] = 1'b1;
        rows_sent++;
    endtask

    task automatic send_bone(input int bone);
        int order [bht_pkg::ROWS];
        int par;
        int tmp;
        int j;
        bit hp;
        order = '{0, 1, 2, 3};
        if ($urandom_range(0, 1)) begin
            for (int i = bht_pkg::ROWS - 1; i > 0; i--) begin
                j        = $urandom_range(0, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
        end
        par = pick_full_bone();
        if (rows_done[bone] == '1 && $urandom_range(0, 7) == 0) par = bone;
        hp = (par >= 0) && ($urandom_range(0, 3) != 0);
        if (!hp) par = $urandom_range(0, bht_pkg::MAX_BONES_DEF - 1);
        for (int i = 0; i < bht_pkg::ROWS; i++) begin
            push_row(make_row(pick_elem(), pick_elem(), pick_elem(), pick_elem(),
                              order[i], bone, hp, par));
        end
    endtask

    initial begin : stimulus
        int start;
        int n;
        int par;
        bit hp;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_beat  = '0;
        for (int i = 0; i < bht_pkg::MAX_BONES_DEF; i++) rows_done[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // root bone of extremes
        push_row(make_row(Q_MAX, Q_MIN, '0, -1, 0, 0, 0, 63));
        push_row(make_row(Q_MIN, Q_MAX, -1, '0, 1, 0, 0, 63));
        push_row(make_row(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 2, 0, 0, 63));
        push_row(make_row(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 3, 0, 0, 63));
        // child of the extremes: saturation both ways and floor of tiny products
        push_row(make_row(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, 1, 1, 0));
        push_row(make_row(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1, 1, 1, 0));
        push_row(make_row(Q_ONE, '0, '0, '0, 2, 1, 1, 0));
        push_row(make_row(-1, 1, -1, 1, 3, 1, 1, 0));
        // identity root, rows out of order
        push_row(make_row('0, '0, '0, Q_ONE, 3, 2, 0, 0));
        push_row(make_row('0, Q_ONE, '0, '0, 1, 2, 0, 0));
        push_row(make_row(Q_ONE, '0, '0, '0, 0, 2, 0, 0));
        push_row(make_row('0, '0, Q_ONE, '0, 2, 2, 0, 0));
        // fractional child of the identity
        push_row(make_row(32'sh0001_8000, 32'shFFFE_7FFF, 3, -3, 0, 3, 1, 2));
        push_row(make_row(-Q_ONE, 32'sh0000_8000, 32'sh0002_0000, 7, 1, 3, 1, 2));
        push_row(make_row(32'sh0000_0001, -2, Q_ONE, -Q_ONE, 2, 3, 1, 2));
        push_row(make_row(32'sh0003_4000, 32'shFFFF_C001, '0, Q_ONE, 3, 3, 1, 2));
        // bone as its own parent
        push_row(make_row(32'sh0002_0000, -Q_ONE, 32'sh0000_C000, -5, 2, 3, 1, 3));
        // highest bone index, child of the fractional bone
        push_row(make_row(Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 63, 1, 3));
        push_row(make_row(-Q_ONE, 32'sh0000_4000, Q_MAX, '0, 1, 63, 1, 3));
        push_row(make_row(Q_MIN, 1, -1, Q_ONE, 2, 63, 1, 3));
        push_row(make_row('0, '0, '0, '0, 3, 63, 1, 3));

        start = rows_sent;
        while (rows_sent - start < RANDOM_ROWS) begin
            if (rows_sent >= mood_until) begin
                calm       <= ($urandom_range(0, 3) == 0);
                mood_until = rows_sent + $urandom_range(40, 160);
            end
            if ($urandom_range(0, 99) < 80) begin
                send_bone($urandom_range(0, bht_pkg::MAX_BONES_DEF - 1));
            end else begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    par = pick_full_bone();
                    hp  = (par >= 0) && $urandom_range(0, 1);
                    if (!hp) par = $urandom_range(0, bht_pkg::MAX_BONES_DEF - 1);
                    push_row(make_row(pick_elem(), pick_elem(), pick_elem(), pick_elem(),
                                      $urandom_range(0, bht_pkg::ROWS - 1),
                                      $urandom_range(0, bht_pkg::MAX_BONES_DEF - 1),
                                      hp, par));
                end
            end
        end
        in_valid <= 1'b0;
        calm     <= 1'b0;

        do @(negedge clk); while (pending != 0);
        repeat (20) @(posedge clk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/bht_pkg.sv
rtl/core/bht_ram.sv
rtl/core/bht_mac.sv
rtl/core/bone_hierarchy_transform_top.sv
rtl/core/bht_chk.sv
bench/bht_checker.sv
bench/tb_top.sv
